// File: hw/rtl/cst_pkg.sv
// Shared types, constants and the arctangent table for the CORDIC sine/cosine block.
package cst_pkg;

    localparam int XY_W       = 18;
    localparam int Z_W        = 17;
    localparam int ATAN_W     = 14;
    localparam int MAX_ITER   = 15;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic signed [XY_W-1:0] GAIN_Q16     = 18'sd39797;
    localparam logic signed [Z_W-1:0]  QUARTER_TURN = 17'sd16384;
    localparam logic signed [Z_W-1:0]  HALF_TURN    = 17'sd32768;

    typedef struct packed {
        logic                  flip;
        logic signed [Z_W-1:0] z;
    } item_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    function automatic logic [ATAN_W-1:0] atan_turns(input logic [3:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/cst_front.sv
// Input side: accepts angle beats, wraps them into plus or minus half a turn and folds them into the right half plane.
module cst_front (
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,
    input  cst_pkg::q_status_t q_status,
    output logic             q_push,
    output cst_pkg::item_t   q_item
);
    import cst_pkg::*;

    logic signed [Z_W-1:0] angle;

    assign s_axis_tready = !q_status.full;
    assign q_push        = s_axis_tvalid && !q_status.full;
    assign angle         = Z_W'(signed'(s_axis_tdata[15:0]));

    always_comb begin
        priority if (angle > QUARTER_TURN) begin
            q_item.z    = angle - HALF_TURN;
            q_item.flip = 1'b1;
        end else if (angle < -QUARTER_TURN) begin
            q_item.z    = angle + HALF_TURN;
            q_item.flip = 1'b1;
        end else begin
            q_item.z    = angle;
            q_item.flip = 1'b0;
        end
    end

endmodule

// File: hw/rtl/cst_queue.sv
// Short queue of folded angles between the input side and the CORDIC pipeline.
module cst_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cst_pkg::item_t     push_item,
    input  logic               pop,
    output cst_pkg::item_t     pop_item,
    output cst_pkg::q_status_t status
);
    import cst_pkg::*;

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.valid = (count_reg != '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;
    assign pop_item     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/cst_back.sv
// CORDIC rotation pipeline, one stage per iteration, with the final negation and output register.
module cst_back #(
    parameter int ITERATIONS = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cst_pkg::q_status_t   q_status,
    input  cst_pkg::item_t       q_item,
    output logic                 q_pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata
);
    import cst_pkg::*;

    localparam int NS = ITERATIONS + 1;

    logic [NS-1:0]           vld_reg;
    logic signed [XY_W-1:0]  x_reg [NS];
    logic signed [XY_W-1:0]  y_reg [NS];
    logic signed [Z_W-1:0]   z_reg [NS];
    logic [NS-1:0]           flip_reg;
    logic                    out_vld_reg;
    logic signed [XY_W-1:0]  cos_reg, sin_reg;
    logic                    en;

    assign en            = !out_vld_reg || m_axis_tready;
    assign q_pop         = en && q_status.valid;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'b0000, sin_reg, cos_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[NS-2:0], q_status.valid};
            out_vld_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= GAIN_Q16;
            y_reg[0]    <= '0;
            z_reg[0]    <= q_item.z;
            flip_reg[0] <= q_item.flip;
            cos_reg     <= flip_reg[NS-1] ? -x_reg[NS-1] : x_reg[NS-1];
            sin_reg     <= flip_reg[NS-1] ? -y_reg[NS-1] : y_reg[NS-1];
        end
    end

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
        logic signed [XY_W-1:0] xs, ys, x_next, y_next;
        logic signed [Z_W-1:0]  ang, z_next;

        always_comb begin
            xs  = x_reg[k] >>> k;
            ys  = y_reg[k] >>> k;
            ang = signed'(Z_W'(atan_turns(4'(k))));
            if (!z_reg[k][Z_W-1]) begin
                x_next = x_reg[k] - ys;
                y_next = y_reg[k] + xs;
                z_next = z_reg[k] - ang;
            end else begin
                x_next = x_reg[k] + ys;
                y_next = y_reg[k] - xs;
                z_next = z_reg[k] + ang;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                z_reg[k+1]    <= z_next;
                flip_reg[k+1] <= flip_reg[k];
            end
        end
    end

endmodule

// File: hw/rtl/cordic_sincos_turns_q16.sv
// Top level of the CORDIC sine/cosine block for angles in Q.16 turns.
//
//  Channel   Direction  Beat contents (lowest bits first)
//  s_axis    in         tdata[15:0]: angle_turns, rest ignored
//  m_axis    out        tdata[17:0]: cos_value, tdata[35:18]: sin_value, rest zero
//
// One angle beat is taken every cycle while the four-entry queue has room.
// A beat popped from the queue passes through a load stage, one stage per CORDIC
// iteration and an output stage before it leaves.
// A stalled m_axis holds the whole pipeline; the queue then absorbs incoming beats.
// Reset clears the queue and all valid flags; no payload is cleared.
module cordic_sincos_turns_q16 #(
    parameter int ITERATIONS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // angle_turns
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // cos_value, sin_value, zero pad
);
    import cst_pkg::*;

    localparam int INFL_MAX = QDEPTH + ITERATIONS + 2;
    localparam int INFL_W   = $clog2(INFL_MAX + 1);

    q_status_t          q_status;
    item_t              push_item, pop_item;
    logic               q_push, q_pop;
    logic [INFL_W-1:0]  infl_reg, infl_next;
    logic               in_beat, out_beat;

    cst_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    cst_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    cst_back #(
        .ITERATIONS (ITERATIONS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign out_beat  = m_axis_tvalid && m_axis_tready;
    assign infl_next = infl_reg + INFL_W'(in_beat) - INFL_W'(out_beat);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            infl_reg <= '0;
        end else begin
            infl_reg <= infl_next;
        end
    end

    // The number of beats inside the block never exceeds its storage.
    a_infl_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        infl_reg <= INFL_W'(INFL_MAX))
        else $error("more beats in flight than the block can hold");

    // An empty block never presents a result.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (infl_reg == '0) |-> !m_axis_tvalid)
        else $error("result presented with no beat in flight");

    // The pipeline pops the queue only when it holds an entry.
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_status.valid)
        else $error("queue popped while empty");

endmodule

// File: verif/tb_cordic_sincos_turns_q16.sv
// Self-checking testbench for the CORDIC sine/cosine block with angles in Q.16 turns.
module tb_cordic_sincos_turns_q16;
    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    localparam int ITER        = 15;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam int IDLE_PCT    = 8;
    localparam int RANDOM_BEATS = 800;

    localparam int ATAN_STEP [ITER] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
    };

    typedef struct packed {
        logic signed [XY_W-1:0] cos_value;
        logic signed [XY_W-1:0] sin_value;
    } trig_pair_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // angle_turns
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // cos_value, sin_value, zero pad

    logic [63:0] angle_pending [$];
    trig_pair_t  trig_expected [$];
    int          cycle_count = 0;
    int          quiet_cycles = 0;
    int          error_count = 0;
    int          beat_count = 0;

    cordic_sincos_turns_q16 #(.ITERATIONS(ITER)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic trig_pair_t cordic_turns_predict(input logic [63:0] angle);
        logic signed [15:0] wrapped;
        int         z;
        int         x;
        int         y;
        int         xs;
        int         ys;
        bit         negate;
        trig_pair_t res;
        wrapped = angle[15:0];
        z = wrapped;
        negate = 1'b0;
        x = 39797;
        y = 0;
        if (z > 16384) begin
            z = z - 32768;
            negate = 1'b1;
        end else if (z < -16384) begin
            z = z + 32768;
            negate = 1'b1;
        end
        for (int i = 0; i < ITER; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
        end
        if (negate) begin
            x = -x;
            y = -y;
        end
        res.cos_value = x[XY_W-1:0];
        res.sin_value = y[XY_W-1:0];
        return res;
    endfunction

    // Both sides run without gaps for a stretch in the middle of the random part.
    function automatic bit take_break();
        if (cycle_count >= 300 && cycle_count < 600)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("beat %0d: %s is %0d, expected %0d", beat_count, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                trig_expected.push_back(cordic_turns_predict(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (angle_pending.size() > 0 && !take_break()) begin
                    s_axis_tdata  <= angle_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        trig_pair_t want;
        m_axis_tready <= !take_break();
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (trig_expected.size() == 0) begin
                report_mismatch("unexpected beat, tdata", m_axis_tdata, 0);
            end else begin
                want = trig_expected.pop_front();
                if ($signed(m_axis_tdata[17:0]) !== want.cos_value)
                    report_mismatch("cos_value", $signed(m_axis_tdata[17:0]), want.cos_value);
                if ($signed(m_axis_tdata[35:18]) !== want.sin_value)
                    report_mismatch("sin_value", $signed(m_axis_tdata[35:18]), want.sin_value);
                if (m_axis_tdata[39:36] !== 4'b0)
                    report_mismatch("pad bits", m_axis_tdata[39:36], 0);
            end
            beat_count++;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic wait_for_drain();
        while (angle_pending.size() > 0 || s_axis_tvalid || trig_expected.size() > 0)
            @(negedge aclk);
    endtask

    initial begin
        logic [63:0] angle;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero, +-1, eighths, quarters and just beyond, 3/8, half turn, upper bits set.
        angle_pending.push_back(64'd0);
        angle_pending.push_back(64'd16384);
        angle_pending.push_back(-64'sd16384);
        angle_pending.push_back(64'd16385);
        angle_pending.push_back(-64'sd16385);
        angle_pending.push_back(-64'sd32768);
        angle_pending.push_back(64'd32767);
        angle_pending.push_back(64'd32768);
        angle_pending.push_back(64'd1);
        angle_pending.push_back(-64'sd1);
        angle_pending.push_back(64'd8192);
        angle_pending.push_back(-64'sd8192);
        angle_pending.push_back(64'd24576);
        angle_pending.push_back(-64'sd24576);
        angle_pending.push_back(64'h8000_0000_0000_0000);
        angle_pending.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        angle_pending.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        angle_pending.push_back(64'h5555_5555_5555_5555);
        angle_pending.push_back(64'h1234_5678_0001_4000);
        angle_pending.push_back(64'hFFFF_FFFF_FFFF_C000);
        wait_for_drain();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            angle = {$urandom, $urandom};
            if ($urandom_range(9) == 0)
                angle[15:0] = 16'h4000 + 16'($urandom_range(2)) - 16'd1;
            else if ($urandom_range(9) == 0)
                angle[15:0] = 16'hC000 + 16'($urandom_range(2)) - 16'd1;
            angle_pending.push_back(angle);
            if (n == RANDOM_BEATS / 2)
                wait_for_drain();
        end
        wait_for_drain();
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (error_count == 0 && trig_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cst_pkg.sv
hw/rtl/cst_front.sv
hw/rtl/cst_queue.sv
hw/rtl/cst_back.sv
hw/rtl/cordic_sincos_turns_q16.sv
verif/tb_cordic_sincos_turns_q16.sv
